// ===== rtl/core/grdq_pkg.sv =====
// ---------------------------------------------------------------------------
// grdq_pkg: shared types and constants for the delta quaternion pipeline
// Holds the cell data types, the pipeline side-band types, the fixed-point
// angle constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`default_nettype none

package grdq_pkg;

   // pipeline depths
   localparam int CORDIC_STAGES = 24;
   localparam int SQRT_STAGES   = 32;
   localparam int DIV_STAGES    = 31;
   localparam int MOD_STEPS     = 5;

   // fixed-point constants
   localparam logic [31:0]        PERIOD_RESET = 32'd42949673;
   localparam logic [31:0]        ONE_Q30      = 32'h4000_0000;
   localparam logic [63:0]        TWO_PI_Q56   = 64'h0648_7ED5_110B_4612;
   localparam logic signed [34:0] PI_Q30       = 35'sd3373259426;
   localparam logic signed [34:0] HALF_PI_Q30  = 35'sd1686629713;
   localparam logic signed [34:0] TWO_PI_Q30   = 35'sd6746518852;

   // square root cell data: remainder and partial root
   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] root;
   } sqrt_type;

   // divider cell data: remainder, divisor and partial quotient
   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] den;
      logic [30:0] quo;
   } div_type;

   // cordic cell data, all fields two's complement
   typedef struct packed {
      logic [33:0] x;
      logic [33:0] y;
      logic [33:0] z;
   } cordic_type;

   // side-band while the magnitude is formed
   typedef struct packed {
      logic             valid;
      logic [2:0][31:0] rate;
   } rate_side_type;

   // side-band through the angle reduction
   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [31:0]      omega;
      logic [2:0][31:0] rate;
   } angle_side_type;

   // side-band through the cordic cells
   typedef struct packed {
      logic             valid;
      logic             zero;
      logic             neg_cos;
      logic [31:0]      omega;
      logic [2:0][31:0] rate;
   } cordic_side_type;

   // side-band through the vector part dividers
   typedef struct packed {
      logic        valid;
      logic        zero;
      logic [2:0]  psign;
      logic        cw_sign;
      logic [31:0] cw_mag;
   } div_side_type;

   // side-band through the norm
   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [3:0]       sign;
      logic [3:0][31:0] mag;
   } norm_side_type;

   // side-band through the normalising dividers
   typedef struct packed {
      logic       valid;
      logic       ident;
      logic [3:0] sign;
   } out_side_type;

   // truncated Q2.30 arctangent of 2^-idx
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000007;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000000;
         5'd31: v = 32'h00000000;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gyro_rate_to_delta_quaternion.sv =====
// ---------------------------------------------------------------------------
// gyro_rate_to_delta_quaternion: gyro sample to unit delta quaternion
// Fully pipelined exponential map from three body rates to the rotation
// quaternion of one sample period.
// ---------------------------------------------------------------------------
// Usage
//   A request (req_rate_x/y/z, signed Q8.24 rad/s) is taken on every clock
//   edge where start is high and busy is low. busy is held low, so a new
//   request may be issued every cycle.
//   The result (rsp_quat_w/x/y/z, signed Q2.30) appears with rsp_valid
//   high for exactly one cycle. Results leave in request order.
//   Throughput is one request per cycle. The pipeline is made of the chains
//   of cells (two 32-cell square roots, 31-cell dividers for the vector part
//   and the normalisation, 24 cordic cells, five reduction steps) and ten
//   single registers.
//   csr_wr_en with csr_wr_data sets the sample period (unsigned Q0.32 s);
//   write it only while nothing is in flight.
//   Reset (synchronous, active high) clears the pipeline valid flags and
//   loads a 10 ms sample period. The receiver cannot stall the output.
// ---------------------------------------------------------------------------
`default_nettype none

module gyro_rate_to_delta_quaternion (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_rate_x,
   input  logic signed [31:0] req_rate_y,
   input  logic signed [31:0] req_rate_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_quat_w,
   output logic signed [31:0] rsp_quat_x,
   output logic signed [31:0] rsp_quat_y,
   output logic signed [31:0] rsp_quat_z,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data
);
   import grdq_pkg::*;

   // sample period register
   logic [31:0] period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   assign busy = 1'b0;

   // request register
   rate_side_type a_side_in;
   rate_side_type a_side_ff;

   always_comb begin
      a_side_in.valid   = start && !busy;
      a_side_in.rate[0] = req_rate_x;
      a_side_in.rate[1] = req_rate_y;
      a_side_in.rate[2] = req_rate_z;
   end

   always_ff @(posedge clock) begin
      if (reset) a_side_ff.valid <= 1'b0;
      else       a_side_ff <= a_side_in;
   end

   // squared rate magnitudes
   logic [31:0]   b_mag [3];
   logic [63:0]   b_sq_in [3];
   logic [63:0]   b_sq_ff [3];
   rate_side_type b_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_mag[i]   = a_side_ff.rate[i][31] ? 32'd0 - a_side_ff.rate[i] : a_side_ff.rate[i];
         b_sq_in[i] = b_mag[i] * b_mag[i];
      end
   end

   always_ff @(posedge clock) begin
      b_sq_ff <= b_sq_in;
      if (reset) b_side_ff.valid <= 1'b0;
      else       b_side_ff <= a_side_ff;
   end

   // sum of squares
   logic [63:0]   c_sum_ff;
   rate_side_type c_side_ff;

   always_ff @(posedge clock) begin
      c_sum_ff <= b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
      if (reset) c_side_ff.valid <= 1'b0;
      else       c_side_ff <= b_side_ff;
   end

   // rate magnitude square root
   sqrt_type      s1 [SQRT_STAGES+1];
   rate_side_type s1_side_ff [SQRT_STAGES];

   assign s1[0] = '{rem: c_sum_ff, root: 32'd0};

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt1
      grdq_sqrt_cell u_cell (
         .clock     (clock),
         .cell_in   (s1[k]),
         .bit_index (5'(SQRT_STAGES - 1 - k)),
         .cell_out  (s1[k+1])
      );
      always_ff @(posedge clock) begin
         if (reset)       s1_side_ff[k].valid <= 1'b0;
         else if (k == 0) s1_side_ff[k] <= c_side_ff;
         else             s1_side_ff[k] <= s1_side_ff[(k == 0) ? 0 : k - 1];
      end
   end

   // half angle product
   logic [31:0]    d_omega;
   logic [63:0]    d_prod;
   logic [63:0]    d_h_ff;
   angle_side_type d_side_in;
   angle_side_type d_side_ff;

   always_comb begin
      d_omega         = s1[SQRT_STAGES].root;
      d_prod          = d_omega * period_ff;
      d_side_in.valid = s1_side_ff[SQRT_STAGES-1].valid;
      d_side_in.zero  = (d_omega == 32'd0);
      d_side_in.omega = d_omega;
      d_side_in.rate  = s1_side_ff[SQRT_STAGES-1].rate;
   end

   always_ff @(posedge clock) begin
      d_h_ff <= d_prod >> 1;
      if (reset) d_side_ff.valid <= 1'b0;
      else       d_side_ff <= d_side_in;
   end

   // reduction modulo two pi, one power-of-two multiple a step
   logic [63:0]    mod_ff [MOD_STEPS];
   angle_side_type mod_side_ff [MOD_STEPS];

   for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
      localparam logic [63:0] STEP_MOD = TWO_PI_Q56 << (MOD_STEPS - 1 - k);
      logic [63:0]    prev;
      angle_side_type prev_side;
      if (k == 0) begin : g_first
         assign prev      = d_h_ff;
         assign prev_side = d_side_ff;
      end else begin : g_next
         assign prev      = mod_ff[k-1];
         assign prev_side = mod_side_ff[k-1];
      end
      always_ff @(posedge clock) begin
         mod_ff[k] <= (prev >= STEP_MOD) ? prev - STEP_MOD : prev;
         if (reset) mod_side_ff[k].valid <= 1'b0;
         else       mod_side_ff[k] <= prev_side;
      end
   end

   // wrap into [-pi, pi] and fold into [-pi/2, pi/2]
   logic signed [34:0] e_raw;
   logic signed [34:0] e_wrap;
   logic signed [34:0] e_fold;
   logic               e_neg;
   logic [33:0]        e_ang_ff;
   cordic_side_type    e_side_in;
   cordic_side_type    e_side_ff;

   always_comb begin
      e_raw  = $signed({2'b00, mod_ff[MOD_STEPS-1][58:26]});
      e_wrap = (e_raw > PI_Q30) ? e_raw - TWO_PI_Q30 : e_raw;
      e_neg  = 1'b0;
      if (e_wrap > HALF_PI_Q30) begin
         e_fold = PI_Q30 - e_wrap;
         e_neg  = 1'b1;
      end else if (e_wrap < -HALF_PI_Q30) begin
         e_fold = -PI_Q30 - e_wrap;
         e_neg  = 1'b1;
      end else begin
         e_fold = e_wrap;
      end
      e_side_in.valid   = mod_side_ff[MOD_STEPS-1].valid;
      e_side_in.zero    = mod_side_ff[MOD_STEPS-1].zero;
      e_side_in.neg_cos = e_neg;
      e_side_in.omega   = mod_side_ff[MOD_STEPS-1].omega;
      e_side_in.rate    = mod_side_ff[MOD_STEPS-1].rate;
   end

   always_ff @(posedge clock) begin
      e_ang_ff <= e_fold[33:0];
      if (reset) e_side_ff.valid <= 1'b0;
      else       e_side_ff <= e_side_in;
   end

   // cordic chain
   cordic_type      cord [CORDIC_STAGES+1];
   cordic_side_type cord_side_ff [CORDIC_STAGES];

   assign cord[0] = '{x: {4'd0, ONE_Q30[29:0]} | 34'h0_4000_0000, y: 34'd0, z: e_ang_ff};

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      grdq_cordic_cell u_cell (
         .clock    (clock),
         .cell_in  (cord[k]),
         .stage    (5'(k)),
         .cell_out (cord[k+1])
      );
      always_ff @(posedge clock) begin
         if (reset)       cord_side_ff[k].valid <= 1'b0;
         else if (k == 0) cord_side_ff[k] <= e_side_ff;
         else             cord_side_ff[k] <= cord_side_ff[(k == 0) ? 0 : k - 1];
      end
   end

   // vector part products and cosine sign
   logic signed [33:0] f_x;
   logic signed [33:0] f_y;
   logic [33:0]        f_x_abs;
   logic [33:0]        f_y_abs;
   logic [31:0]        f_rmag [3];
   logic [63:0]        f_prod_in [3];
   logic [63:0]        f_prod_ff [3];
   logic [31:0]        f_den_ff;
   div_side_type       f_side_in;
   div_side_type       f_side_ff;
   cordic_side_type    f_src;

   always_comb begin
      f_src   = cord_side_ff[CORDIC_STAGES-1];
      f_x     = $signed(cord[CORDIC_STAGES].x);
      f_y     = $signed(cord[CORDIC_STAGES].y);
      f_x_abs = f_x[33] ? 34'(-f_x) : f_x;
      f_y_abs = f_y[33] ? 34'(-f_y) : f_y;
      for (int i = 0; i < 3; i++) begin
         f_rmag[i]          = f_src.rate[i][31] ? 32'd0 - f_src.rate[i] : f_src.rate[i];
         f_prod_in[i]       = f_rmag[i] * f_y_abs[31:0];
         f_side_in.psign[i] = f_src.rate[i][31] ^ f_y[33];
      end
      f_side_in.valid   = f_src.valid;
      f_side_in.zero    = f_src.zero;
      f_side_in.cw_sign = f_x[33] ^ f_src.neg_cos;
      f_side_in.cw_mag  = f_x_abs[31:0];
   end

   always_ff @(posedge clock) begin
      f_prod_ff <= f_prod_in;
      f_den_ff  <= f_src.omega;
      if (reset) f_side_ff.valid <= 1'b0;
      else       f_side_ff <= f_side_in;
   end

   // vector part dividers, rate times sine over magnitude
   div_type      dv1 [3][DIV_STAGES+1];
   div_side_type dv1_side_ff [DIV_STAGES];

   for (genvar j = 0; j < 3; j++) begin : g_div1
      assign dv1[j][0] = '{rem: f_prod_ff[j], den: f_den_ff, quo: 31'd0};
      for (genvar k = 0; k < DIV_STAGES; k++) begin : g_cell
         grdq_div_cell u_cell (
            .clock     (clock),
            .cell_in   (dv1[j][k]),
            .bit_index (5'(DIV_STAGES - 1 - k)),
            .cell_out  (dv1[j][k+1])
         );
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div1_side
      always_ff @(posedge clock) begin
         if (reset)       dv1_side_ff[k].valid <= 1'b0;
         else if (k == 0) dv1_side_ff[k] <= f_side_ff;
         else             dv1_side_ff[k] <= dv1_side_ff[(k == 0) ? 0 : k - 1];
      end
   end

   // component magnitudes and signs
   norm_side_type g_side_in;
   norm_side_type g_side_ff;

   always_comb begin
      g_side_in.valid   = dv1_side_ff[DIV_STAGES-1].valid;
      g_side_in.zero    = dv1_side_ff[DIV_STAGES-1].zero;
      g_side_in.sign[0] = dv1_side_ff[DIV_STAGES-1].cw_sign;
      g_side_in.mag[0]  = dv1_side_ff[DIV_STAGES-1].cw_mag;
      for (int j = 0; j < 3; j++) begin
         g_side_in.sign[j+1] = dv1_side_ff[DIV_STAGES-1].psign[j];
         g_side_in.mag[j+1]  = {1'b0, dv1[j][DIV_STAGES].quo};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) g_side_ff.valid <= 1'b0;
      else       g_side_ff <= g_side_in;
   end

   // squares of the halved magnitudes
   logic [30:0]   h_half [4];
   logic [61:0]   h_sq_in [4];
   logic [61:0]   h_sq_ff [4];
   norm_side_type h_side_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         h_half[i]  = g_side_ff.mag[i][31:1];
         h_sq_in[i] = h_half[i] * h_half[i];
      end
   end

   always_ff @(posedge clock) begin
      h_sq_ff <= h_sq_in;
      if (reset) h_side_ff.valid <= 1'b0;
      else       h_side_ff <= g_side_ff;
   end

   // norm sum of squares
   logic [63:0]   i_sum_ff;
   norm_side_type i_side_ff;

   always_ff @(posedge clock) begin
      i_sum_ff <= {2'b00, h_sq_ff[0]} + {2'b00, h_sq_ff[1]}
                + {2'b00, h_sq_ff[2]} + {2'b00, h_sq_ff[3]};
      if (reset) i_side_ff.valid <= 1'b0;
      else       i_side_ff <= h_side_ff;
   end

   // norm square root
   sqrt_type      s2 [SQRT_STAGES+1];
   norm_side_type s2_side_ff [SQRT_STAGES];

   assign s2[0] = '{rem: i_sum_ff, root: 32'd0};

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt2
      grdq_sqrt_cell u_cell (
         .clock     (clock),
         .cell_in   (s2[k]),
         .bit_index (5'(SQRT_STAGES - 1 - k)),
         .cell_out  (s2[k+1])
      );
      always_ff @(posedge clock) begin
         if (reset)       s2_side_ff[k].valid <= 1'b0;
         else if (k == 0) s2_side_ff[k] <= i_side_ff;
         else             s2_side_ff[k] <= s2_side_ff[(k == 0) ? 0 : k - 1];
      end
   end

   // normalising dividers
   logic [31:0]   n_norm;
   norm_side_type n_src;
   out_side_type  n_side;
   div_type       dv2 [4][DIV_STAGES+1];
   out_side_type  dv2_side_ff [DIV_STAGES];

   always_comb begin
      n_norm       = s2[SQRT_STAGES].root;
      n_src        = s2_side_ff[SQRT_STAGES-1];
      n_side.valid = n_src.valid;
      n_side.ident = n_src.zero || (n_norm == 32'd0);
      n_side.sign  = n_src.sign;
   end

   for (genvar j = 0; j < 4; j++) begin : g_div2
      assign dv2[j][0] = '{rem: {3'b000, n_src.mag[j], 29'd0}, den: n_norm, quo: 31'd0};
      for (genvar k = 0; k < DIV_STAGES; k++) begin : g_cell
         grdq_div_cell u_cell (
            .clock     (clock),
            .cell_in   (dv2[j][k]),
            .bit_index (5'(DIV_STAGES - 1 - k)),
            .cell_out  (dv2[j][k+1])
         );
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div2_side
      always_ff @(posedge clock) begin
         if (reset)       dv2_side_ff[k].valid <= 1'b0;
         else if (k == 0) dv2_side_ff[k] <= n_side;
         else             dv2_side_ff[k] <= dv2_side_ff[(k == 0) ? 0 : k - 1];
      end
   end

   // signed outputs or identity
   logic [31:0] k_quo [4];
   logic [31:0] k_out_in [4];
   logic [31:0] k_out_ff [4];
   logic        rsp_valid_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         k_quo[j]    = {1'b0, dv2[j][DIV_STAGES].quo};
         k_out_in[j] = dv2_side_ff[DIV_STAGES-1].sign[j] ? 32'd0 - k_quo[j] : k_quo[j];
      end
      if (dv2_side_ff[DIV_STAGES-1].ident) begin
         k_out_in[0] = ONE_Q30;
         k_out_in[1] = 32'd0;
         k_out_in[2] = 32'd0;
         k_out_in[3] = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      k_out_ff <= k_out_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv2_side_ff[DIV_STAGES-1].valid;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_w = $signed(k_out_ff[0]);
   assign rsp_quat_x = $signed(k_out_ff[1]);
   assign rsp_quat_y = $signed(k_out_ff[2]);
   assign rsp_quat_z = $signed(k_out_ff[3]);

   // zero magnitude only for an all-zero rate request
   assert property (@(posedge clock) disable iff (reset)
      (d_side_ff.valid && d_side_ff.zero) |->
      (d_side_ff.rate[0] == 32'd0 && d_side_ff.rate[1] == 32'd0 &&
       d_side_ff.rate[2] == 32'd0))
      else $error("zero magnitude flagged for non-zero rates");

   // reduced half angle lies below two pi
   assert property (@(posedge clock) disable iff (reset)
      mod_side_ff[MOD_STEPS-1].valid |-> (mod_ff[MOD_STEPS-1] < TWO_PI_Q56))
      else $error("angle reduction left a remainder of two pi or more");

   // folded angle within the cordic range
   assert property (@(posedge clock) disable iff (reset)
      e_side_ff.valid |->
      ($signed(e_ang_ff) <= HALF_PI_Q30 && $signed(e_ang_ff) >= -HALF_PI_Q30))
      else $error("cordic angle outside plus or minus half pi");

endmodule

`default_nettype wire

// ===== rtl/core/grdq_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// grdq_sqrt_cell: one root bit of an integer square root
// Tests one root bit against the remainder and registers the updated pair.
// ---------------------------------------------------------------------------
`default_nettype none

module grdq_sqrt_cell (
   input  logic               clock,
   input  grdq_pkg::sqrt_type cell_in,
   input  logic [4:0]         bit_index,
   output grdq_pkg::sqrt_type cell_out
);
   import grdq_pkg::*;

   logic [5:0]  root_shift;
   logic [65:0] trial;
   logic [65:0] rem_wide;
   sqrt_type    result_in;
   sqrt_type    result_ff;

   // (root + 2^i)^2 - root^2 against the remainder
   always_comb begin
      root_shift = {1'b0, bit_index} + 6'd1;
      trial      = ({34'd0, cell_in.root} << root_shift) + (66'd1 << {bit_index, 1'b0});
      rem_wide   = {2'b00, cell_in.rem};
      result_in  = cell_in;
      if (rem_wide >= trial) begin
         result_in.rem  = 64'(rem_wide - trial);
         result_in.root = cell_in.root | (32'd1 << bit_index);
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign cell_out = result_ff;

endmodule

`default_nettype wire

// ===== rtl/core/grdq_div_cell.sv =====
// ---------------------------------------------------------------------------
// grdq_div_cell: one quotient bit of a restoring divider
// Subtracts the shifted divisor when it fits and passes the divisor on.
// ---------------------------------------------------------------------------
`default_nettype none

module grdq_div_cell (
   input  logic              clock,
   input  grdq_pkg::div_type cell_in,
   input  logic [4:0]        bit_index,
   output grdq_pkg::div_type cell_out
);
   import grdq_pkg::*;

   logic [63:0] trial;
   div_type     result_in;
   div_type     result_ff;

   // compare and subtract one shifted divisor
   always_comb begin
      trial     = {32'd0, cell_in.den} << bit_index;
      result_in = cell_in;
      if (cell_in.rem >= trial) begin
         result_in.rem = cell_in.rem - trial;
         result_in.quo = cell_in.quo | (31'd1 << bit_index);
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign cell_out = result_ff;

endmodule

`default_nettype wire

// ===== rtl/core/grdq_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// grdq_cordic_cell: one rotation-mode cordic micro-rotation
// Rotates by plus or minus atan(2^-i) towards a zero residual angle.
// ---------------------------------------------------------------------------
`default_nettype none

module grdq_cordic_cell (
   input  logic                 clock,
   input  grdq_pkg::cordic_type cell_in,
   input  logic [4:0]           stage,
   output grdq_pkg::cordic_type cell_out
);
   import grdq_pkg::*;

   logic signed [33:0] x_cur;
   logic signed [33:0] y_cur;
   logic signed [33:0] z_cur;
   logic signed [33:0] x_shift;
   logic signed [33:0] y_shift;
   logic signed [33:0] angle_step;
   cordic_type         result_in;
   cordic_type         result_ff;

   // floor shifts and direction from the residual sign
   always_comb begin
      x_cur      = $signed(cell_in.x);
      y_cur      = $signed(cell_in.y);
      z_cur      = $signed(cell_in.z);
      x_shift    = x_cur >>> stage;
      y_shift    = y_cur >>> stage;
      angle_step = $signed({2'b00, atan_q30(stage)});
      if (!z_cur[33]) begin
         result_in.x = x_cur - y_shift;
         result_in.y = y_cur + x_shift;
         result_in.z = z_cur - angle_step;
      end else begin
         result_in.x = x_cur + y_shift;
         result_in.y = y_cur - x_shift;
         result_in.z = z_cur + angle_step;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign cell_out = result_ff;

endmodule

`default_nettype wire
